// ----- rtl/irass_pkg.sv -----
// Package for the IR ambient-subtract scan sequencer.
// Holds field widths, phase codes and the scan control record; no dependencies.
package irass_pkg;

    localparam int READING_W            = 12;
    localparam int COUNT_W              = 31;
    localparam int PHASE_W              = 3;
    localparam int EMIT_W               = 4;
    localparam int NUM_SENSORS          = 4;
    localparam int READING_BITS_DEFAULT = 12;

    localparam logic [PHASE_W-1:0] PHASE_DARK        = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_SIDE_LEFT   = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_FRONT_LEFT  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_FRONT_RIGHT = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_SIDE_RIGHT  = 3'd4;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [EMIT_W-1:0]  emitters;
        logic               host_lock;
    } scan_ctl_t;

endpackage

// ----- rtl/irass_step.sv -----
// Next-state logic for one scan tick: park, baseline capture, lit-minus-dark, publish.
// Depends on irass_pkg.
module irass_step
    import irass_pkg::*;
#(
    parameter int SAMPLE_W = READING_W
)
(
    input  logic                                   enable,
    input  logic                                   host,
    input  logic [NUM_SENSORS-1:0][SAMPLE_W-1:0]   rd,
    input  scan_ctl_t                              ctl,
    input  logic [NUM_SENSORS-1:0][SAMPLE_W-1:0]   baseline,
    input  logic [NUM_SENSORS-1:0][SAMPLE_W-1:0]   build,
    input  logic [NUM_SENSORS-1:0][SAMPLE_W-1:0]   published,
    input  logic [COUNT_W-1:0]                     count,
    output scan_ctl_t                              ctl_next,
    output logic [NUM_SENSORS-1:0][SAMPLE_W-1:0]   baseline_next,
    output logic [NUM_SENSORS-1:0][SAMPLE_W-1:0]   build_next,
    output logic [NUM_SENSORS-1:0][SAMPLE_W-1:0]   published_next,
    output logic [COUNT_W-1:0]                     count_next,
    output logic                                   publish
);

    logic [PHASE_W-1:0]  ph0;
    logic [EMIT_W-1:0]   em0;
    logic [1:0]          k;
    logic [2:0]          k_up;
    logic [SAMPLE_W-1:0] lit;
    logic [SAMPLE_W-1:0] dark;
    logic [SAMPLE_W-1:0] diff;
    logic                park_now;

    assign park_now = host && !ctl.host_lock && enable;
    assign ph0      = park_now ? PHASE_DARK : ctl.phase;
    assign em0      = park_now ? '0 : ctl.emitters;
    assign k        = 2'(ph0 - 3'd1);
    assign k_up     = {1'b0, k} + 3'd1;
    assign lit      = rd[k];
    assign dark     = baseline[k];
    assign diff     = (lit > dark) ? (lit - dark) : '0;

    always_comb
    begin
        ctl_next           = ctl;
        ctl_next.phase     = ph0;
        ctl_next.emitters  = em0;
        ctl_next.host_lock = host;
        baseline_next      = baseline;
        build_next         = build;
        published_next     = published;
        count_next         = count;
        publish            = 1'b0;
        if (enable && !host)
        begin
            if (ph0 == PHASE_DARK || ph0 > PHASE_SIDE_RIGHT)
            begin
                baseline_next     = rd;
                ctl_next.emitters = EMIT_W'(1);
                ctl_next.phase    = PHASE_SIDE_LEFT;
            end
            else
            begin
                build_next[k]     = diff;
                ctl_next.emitters = em0 & ~(EMIT_W'(1) << k);
                if (ph0 < PHASE_SIDE_RIGHT)
                begin
                    ctl_next.emitters = (em0 & ~(EMIT_W'(1) << k)) | (EMIT_W'(1) << k_up);
                    ctl_next.phase    = ph0 + 3'd1;
                end
                else
                begin
                    published_next    = build;
                    published_next[k] = diff;
                    count_next        = count + 1'b1;
                    publish           = 1'b1;
                    ctl_next.phase    = PHASE_DARK;
                end
            end
        end
    end

endmodule

// ----- rtl/ir_ambient_subtract_scan_sequencer_core.sv -----
// Top level of the IR ambient-subtract scan sequencer: input register, step logic, result register.
// Depends on irass_pkg and irass_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one tick: host_owns_adc and four
//   averaged detector readings. Output channel (out_valid/out_ready) returns one
//   beat per tick: emitter drive, phase after the tick, publish flag, the latest
//   published differences and the completed-set count.
//   cfg_write_en/cfg_write_data write sampler_enable; every write parks the scan
//   (dark phase, emitters off). Write only while no beat is in flight.
//   Pipeline: a tick is held in the input register, and its result is written
//   to the result register once that register is empty or being read.
//   Throughput: one tick per cycle while the receiver takes beats; each tick
//   needs only a subtract, a compare and register updates in the step logic.
//   Reset clears the scan to the dark phase, emitters off, baselines, partial
//   and published sets and the count to zero, sampler disabled.
//   When the receiver stalls, the result register holds its beat and the input
//   register still takes one more tick; in_ready drops only when both are full.
module ir_ambient_subtract_scan_sequencer_core
    import irass_pkg::*;
#(
    parameter int READING_BITS = READING_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic                  cfg_write_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  host_owns_adc,
    input  logic [READING_W-1:0]  reading_side_left,
    input  logic [READING_W-1:0]  reading_front_left,
    input  logic [READING_W-1:0]  reading_front_right,
    input  logic [READING_W-1:0]  reading_side_right,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [EMIT_W-1:0]     emitters_on,
    output logic [PHASE_W-1:0]    scan_phase,
    output logic                  set_published,
    output logic [READING_W-1:0]  diff_side_left,
    output logic [READING_W-1:0]  diff_front_left,
    output logic [READING_W-1:0]  diff_front_right,
    output logic [READING_W-1:0]  diff_side_right,
    output logic [COUNT_W-1:0]    sets_completed
);

    localparam int SAMPLE_W = (READING_BITS < READING_W) ? READING_BITS : READING_W;

    typedef logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] sample_set_t;

    logic          in_valid_reg;
    logic          in_host_reg;
    sample_set_t   in_rd_reg;
    logic          out_valid_reg;
    logic          advance;

    logic          enable_reg;
    scan_ctl_t     ctl_reg;
    scan_ctl_t     ctl_next;
    sample_set_t   baseline_reg;
    sample_set_t   baseline_next;
    sample_set_t   build_reg;
    sample_set_t   build_next;
    sample_set_t   published_reg;
    sample_set_t   published_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic          publish_next;

    logic [EMIT_W-1:0]  emit_out_reg;
    logic [PHASE_W-1:0] phase_out_reg;
    logic               pub_out_reg;
    sample_set_t        diff_out_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic          step_fire;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign step_fire = in_valid_reg && advance;

    irass_step #(
        .SAMPLE_W (SAMPLE_W)
    ) u_step (
        .enable         (enable_reg),
        .host           (in_host_reg),
        .rd             (in_rd_reg),
        .ctl            (ctl_reg),
        .baseline       (baseline_reg),
        .build          (build_reg),
        .published      (published_reg),
        .count          (count_reg),
        .ctl_next       (ctl_next),
        .baseline_next  (baseline_next),
        .build_next     (build_next),
        .published_next (published_next),
        .count_next     (count_next),
        .publish        (publish_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_host_reg  <= host_owns_adc;
            in_rd_reg[0] <= reading_side_left[SAMPLE_W-1:0];
            in_rd_reg[1] <= reading_front_left[SAMPLE_W-1:0];
            in_rd_reg[2] <= reading_front_right[SAMPLE_W-1:0];
            in_rd_reg[3] <= reading_side_right[SAMPLE_W-1:0];
        end
        if (step_fire)
        begin
            emit_out_reg  <= ctl_next.emitters;
            phase_out_reg <= ctl_next.phase;
            pub_out_reg   <= publish_next;
            diff_out_reg  <= published_next;
            count_out_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            ctl_reg       <= '0;
            baseline_reg  <= '0;
            build_reg     <= '0;
            published_reg <= '0;
            count_reg     <= '0;
        end
        else if (cfg_write_en)
        begin
            enable_reg       <= cfg_write_data;
            ctl_reg.phase    <= PHASE_DARK;
            ctl_reg.emitters <= '0;
        end
        else if (step_fire)
        begin
            ctl_reg       <= ctl_next;
            baseline_reg  <= baseline_next;
            build_reg     <= build_next;
            published_reg <= published_next;
            count_reg     <= count_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign emitters_on      = emit_out_reg;
    assign scan_phase       = phase_out_reg;
    assign set_published    = pub_out_reg;
    assign diff_side_left   = READING_W'(diff_out_reg[0]);
    assign diff_front_left  = READING_W'(diff_out_reg[1]);
    assign diff_front_right = READING_W'(diff_out_reg[2]);
    assign diff_side_right  = READING_W'(diff_out_reg[3]);
    assign sets_completed   = count_out_reg;

    a_one_emitter: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ctl_reg.emitters))
        else $error("more than one emitter lit");

    a_phase_matches_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.phase == PHASE_DARK) == (ctl_reg.emitters == '0))
        else $error("emitter drive disagrees with scan phase");

    a_publish_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && publish_next && !cfg_write_en |=>
            count_reg == $past(count_reg) + 1'b1)
        else $error("published set not counted");

    a_publish_parks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pub_out_reg |-> phase_out_reg == PHASE_DARK && emit_out_reg == '0)
        else $error("publish beat not in dark phase");

endmodule
